/* rtl/core/internet_checksum_encap_defines.svh */
// Assertion macros shared by the internet checksum block's checkers.
`ifndef INTERNET_CHECKSUM_ENCAP_DEFINES_SVH
`define INTERNET_CHECKSUM_ENCAP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ICK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ICK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ick_pkg.sv */
// Types, constants and sum helpers for the internet checksum block.
package ick_pkg;

	localparam int unsigned DATA_W    = 8;
	localparam int unsigned SUM_W     = 16;
	localparam int unsigned IDX_W     = 5;
	localparam int unsigned PROTO_W   = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = 2;

	localparam logic [IDX_W-1:0] IDX_MAX = 5'd31;

	localparam logic [PROTO_W-1:0] PROTO_UDP  = 2'd0;
	localparam logic [PROTO_W-1:0] PROTO_TCP  = 2'd1;
	localparam logic [PROTO_W-1:0] PROTO_IPV4 = 2'd2;
	localparam logic [PROTO_W-1:0] PROTO_NONE = 2'd3;

	localparam logic [IDX_W-1:0] UDP_BASE  = 5'd6;
	localparam logic [IDX_W-1:0] TCP_BASE  = 5'd16;
	localparam logic [IDX_W-1:0] IPV4_BASE = 5'd10;

	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_SELECT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENCAPSULATE     = 1'b1;

	localparam logic [SUM_W-1:0] SUM_ALL_ONES = 16'hFFFF;

	typedef struct packed {
		logic [PROTO_W-1:0] protocol_select;
		logic               encapsulate;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              last;
	} beat_t;

	// One's-complement add with end-around carry.
	function automatic logic [SUM_W-1:0] ones_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
	endfunction

	// True where encapsulate is set and the byte at idx lies in the selected checksum field.
	function automatic logic is_zeroed(input cfg_t cfg, input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] base;
		logic             hit;
		base = UDP_BASE;
		hit  = 1'b1;
		unique case (cfg.protocol_select)
			PROTO_UDP:  base = UDP_BASE;
			PROTO_TCP:  base = TCP_BASE;
			PROTO_IPV4: base = IPV4_BASE;
			PROTO_NONE: hit  = 1'b0;
			default:    hit  = 1'b0;
		endcase
		return cfg.encapsulate && hit && (idx == base || idx == base + 5'd1);
	endfunction

endpackage

/* rtl/core/ick_in_stage.sv */
// Input register stage: captures one byte beat and hands it to the sum stage.
module ick_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ick_pkg::DATA_W-1:0] s_tdata,  // data_byte[7:0]
	input  logic                      s_tlast,  // last_byte
	input  logic                      adv,
	output logic                      valid_s1,
	output ick_pkg::beat_t            beat_s1
);
	import ick_pkg::*;

	// Take a beat when empty or when the held beat moves on this cycle.
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.data <= s_tdata;
			beat_s1.last <= s_tlast;
		end
	end

endmodule

/* rtl/core/ick_sum.sv */
// Running one's-complement sum, field zeroing and result register.
module ick_sum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ick_pkg::cfg_t             cfg,
	input  logic                      valid_s1,
	input  ick_pkg::beat_t            beat_s1,
	output logic                      adv,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ick_pkg::SUM_W-1:0] m_tdata
);
	import ick_pkg::*;

	logic [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0] held_q;
	logic              odd_q;
	logic [IDX_W-1:0]  idx_q;

	logic              res_valid_s2;
	logic [SUM_W-1:0]  res_s2;

	logic [DATA_W-1:0] byte_z;
	logic [SUM_W-1:0]  word;
	logic [SUM_W-1:0]  sum_word;
	logic [SUM_W-1:0]  fin;

	assign adv = valid_s1 && (!res_valid_s2 || m_tready);

	always_comb begin
		byte_z   = is_zeroed(cfg, idx_q) ? '0 : beat_s1.data;
		// On an even position a last byte pairs with a zero pad byte.
		word     = odd_q ? {held_q, byte_z} : {byte_z, {DATA_W{1'b0}}};
		sum_word = ones_add(sum_q, word);
		fin      = ~sum_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q        <= '0;
			held_q       <= '0;
			odd_q        <= 1'b0;
			idx_q        <= '0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (m_tready) begin
				res_valid_s2 <= 1'b0;
			end
			if (adv) begin
				if (beat_s1.last) begin
					sum_q        <= '0;
					held_q       <= '0;
					odd_q        <= 1'b0;
					idx_q        <= '0;
					res_valid_s2 <= 1'b1;
				end else begin
					if (idx_q != IDX_MAX) begin
						idx_q <= idx_q + 5'd1;
					end
					if (odd_q) begin
						sum_q  <= sum_word;
						held_q <= '0;
						odd_q  <= 1'b0;
					end else begin
						held_q <= byte_z;
						odd_q  <= 1'b1;
					end
				end
			end
		end
	end

	// Send a zero checksum as all ones.
	always_ff @(posedge clk) begin
		if (adv && beat_s1.last) begin
			res_s2 <= (fin == '0) ? SUM_ALL_ONES : fin;
		end
	end

	assign m_tvalid = res_valid_s2;
	assign m_tdata  = res_s2;

endmodule

/* rtl/core/internet_checksum_encap.sv */
// Top level of the streaming internet checksum block.
//
// Packet bytes enter one per beat on the slave stream, first byte first,
// with tlast on the final byte; one 16-bit checksum leaves on the master
// stream for each packet. Byte pairs are summed big-endian in one's
// complement; with encapsulate set, the checksum field of the selected
// protocol (UDP bytes 6-7, TCP 16-17, IPv4 10-11, none) counts as zero.
// An odd final byte is padded with zero and a zero result is sent as
// 0xFFFF. The block takes one byte every cycle while the master stream
// keeps up; the checksum is offered once its last byte has passed the input
// register and the single add-and-fold into the result register. While a
// checksum waits on the master stream, the beat in the input register is
// held, so the slave stream stalls after taking at most one more beat.
// Write the configuration only while no packet is in flight.
module internet_checksum_encap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ick_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ick_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // data_byte[7:0]
	input  logic                          s_tlast,  // last_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata   // checksum_value[15:0]
);
	import ick_pkg::*;

	cfg_t  cfg_q;
	logic  valid_s1;
	beat_t beat_s1;
	logic  adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.protocol_select <= PROTO_UDP;
			cfg_q.encapsulate     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROTOCOL_SELECT: cfg_q.protocol_select <= cfg_wdata[PROTO_W-1:0];
				REG_ENCAPSULATE:     cfg_q.encapsulate     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	ick_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	ick_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* rtl/core/ick_checker.sv */
// Port-level checks for the internet checksum block, bound to its top level.
`include "internet_checksum_encap_defines.svh"

module ick_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	// Packets whose last beat went in and whose checksum has not left yet.
	logic [1:0] pend_q;
	logic       last_in;
	logic       res_out;

	assign last_in = s_tvalid && s_tready && s_tlast;
	assign res_out = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else if (last_in && !res_out) begin
			pend_q <= pend_q + 2'd1;
		end else if (res_out && !last_in) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	`ICK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled checksum changed")
	`ICK_ASSERT_NOW(a_no_zero, m_tvalid, m_tdata != 16'h0000, "checksum of zero sent")
	`ICK_ASSERT_NOW(a_out_owed, m_tvalid, pend_q != 2'd0, "checksum without a last beat")
	`ICK_ASSERT_NOW(a_depth, 1'b1, pend_q != 2'd3, "more packets in flight than stages")
	`ICK_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind internet_checksum_encap ick_checker u_ick_checker (.*);
